/* design/assert_macros.svh */
// Assertion macros shared by the scanner RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("assertion failed: invariant");

// Same-cycle implication.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: implication");

// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next cycle");

`endif

/* design/jts_pkg.sv */
// Types, constants and keyword tables of the JSON token scanner.
`default_nettype none

package jts_pkg;

  localparam int QUEUE_DEPTH  = 4;
  localparam int OUTBUF_DEPTH = 4;

  // Keyword selectors.
  localparam logic [1:0] KW_TRUE  = 2'd0;
  localparam logic [1:0] KW_FALSE = 2'd1;
  localparam logic [1:0] KW_NULL  = 2'd2;

  typedef enum logic [3:0] {
    KIND_STRING   = 4'd0,
    KIND_NUMBER   = 4'd1,
    KIND_BOOL     = 4'd2,
    KIND_NULL     = 4'd3,
    KIND_LBRACE   = 4'd4,
    KIND_RBRACE   = 4'd5,
    KIND_LBRACKET = 4'd6,
    KIND_RBRACKET = 4'd7,
    KIND_COLON    = 4'd8,
    KIND_COMMA    = 4'd9,
    KIND_FINISH   = 4'd10,
    KIND_ERROR    = 4'd11
  } kind_t;

  // Byte classes as seen between tokens.
  typedef enum logic [3:0] {
    CC_SPACE,
    CC_DQUOTE,
    CC_SQUOTE,
    CC_KEY_T,
    CC_KEY_F,
    CC_KEY_N,
    CC_PUNCT,
    CC_NUMSTART,
    CC_OTHER
  } char_class_t;

  typedef enum logic [1:0] {
    MODE_IDLE,
    MODE_STR,
    MODE_NUM,
    MODE_KEY
  } mode_t;

  typedef struct packed {
    logic [7:0]  data;
    logic        eoi;
    char_class_t cls;
    logic        numeric;
    logic        flt;
    logic        neg;
    kind_t       punct_kind;
  } cls_item_t;

  typedef struct packed {
    logic      valid;
    cls_item_t item;
  } q_head_t;

  typedef struct packed {
    kind_t       kind;
    logic [15:0] start;
    logic [15:0] length;
    logic        flt;
    logic        neg;
    logic        bv;
    logic        last;
  } rec_t;

  typedef struct packed {
    logic [1:0] n;
    rec_t       r0;
    rec_t       r1;
  } push_t;

  typedef struct packed {
    logic [2:0] free;
  } ob_stat_t;

  // Expected letter of keyword sel at position pos (true, false, null).
  function automatic logic [7:0] kw_char(input logic [1:0] sel, input logic [2:0] pos);
    logic [7:0] c;
    c = 8'h00;
    unique case (sel)
      KW_TRUE: begin
        unique case (pos)
          3'd0: c = 8'h74;
          3'd1: c = 8'h72;
          3'd2: c = 8'h75;
          3'd3: c = 8'h65;
          default: c = 8'h00;
        endcase
      end
      KW_FALSE: begin
        unique case (pos)
          3'd0: c = 8'h66;
          3'd1: c = 8'h61;
          3'd2: c = 8'h6C;
          3'd3: c = 8'h73;
          3'd4: c = 8'h65;
          default: c = 8'h00;
        endcase
      end
      default: begin
        unique case (pos)
          3'd0: c = 8'h6E;
          3'd1: c = 8'h75;
          3'd2: c = 8'h6C;
          3'd3: c = 8'h6C;
          default: c = 8'h00;
        endcase
      end
    endcase
    return c;
  endfunction

  function automatic logic [2:0] kw_len(input logic [1:0] sel);
    return (sel == KW_FALSE) ? 3'd5 : 3'd4;
  endfunction

endpackage

`default_nettype wire

/* design/jts_front.sv */
// Front end: accepts input bytes, classifies them and queues them.
`default_nettype none

module jts_front (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  s_tvalid,
  output logic                 s_tready,
  input  wire  [7:0]           s_tdata,   // [7:0] data_byte
  input  wire                  s_tlast,   // end_of_input
  output jts_pkg::q_head_t     head,
  input  wire                  pop
);

  localparam int PW = $clog2(jts_pkg::QUEUE_DEPTH);

  jts_pkg::cls_item_t q [jts_pkg::QUEUE_DEPTH];
  jts_pkg::cls_item_t cur;
  logic [PW-1:0] wp;
  logic [PW-1:0] rp;
  logic [PW:0]   cnt;
  logic          push;

  always_comb begin
    cur            = '0;
    cur.data       = s_tdata;
    cur.eoi        = s_tlast;
    cur.cls        = jts_pkg::CC_OTHER;
    cur.punct_kind = jts_pkg::KIND_FINISH;
    unique case (s_tdata)
      8'h20, 8'h09, 8'h0A, 8'h0D: cur.cls = jts_pkg::CC_SPACE;
      8'h22: cur.cls = jts_pkg::CC_DQUOTE;
      8'h27: cur.cls = jts_pkg::CC_SQUOTE;
      8'h74: cur.cls = jts_pkg::CC_KEY_T;
      8'h66: cur.cls = jts_pkg::CC_KEY_F;
      8'h6E: cur.cls = jts_pkg::CC_KEY_N;
      8'h7B: begin
        cur.cls = jts_pkg::CC_PUNCT;
        cur.punct_kind = jts_pkg::KIND_LBRACE;
      end
      8'h7D: begin
        cur.cls = jts_pkg::CC_PUNCT;
        cur.punct_kind = jts_pkg::KIND_RBRACE;
      end
      8'h5B: begin
        cur.cls = jts_pkg::CC_PUNCT;
        cur.punct_kind = jts_pkg::KIND_LBRACKET;
      end
      8'h5D: begin
        cur.cls = jts_pkg::CC_PUNCT;
        cur.punct_kind = jts_pkg::KIND_RBRACKET;
      end
      8'h3A: begin
        cur.cls = jts_pkg::CC_PUNCT;
        cur.punct_kind = jts_pkg::KIND_COLON;
      end
      8'h2C: begin
        cur.cls = jts_pkg::CC_PUNCT;
        cur.punct_kind = jts_pkg::KIND_COMMA;
      end
      8'h00: begin
        cur.cls = jts_pkg::CC_PUNCT;
        cur.punct_kind = jts_pkg::KIND_FINISH;
      end
      8'h2D: begin
        cur.cls = jts_pkg::CC_NUMSTART;
        cur.numeric = 1'b1;
        cur.neg = 1'b1;
      end
      // plus continues a number but cannot start one
      8'h2B: cur.numeric = 1'b1;
      8'h2E, 8'h65, 8'h45: begin
        cur.numeric = 1'b1;
        cur.flt = 1'b1;
      end
      default: begin
        if (s_tdata >= 8'h30 && s_tdata <= 8'h39) begin
          cur.cls = jts_pkg::CC_NUMSTART;
          cur.numeric = 1'b1;
        end
      end
    endcase
  end

  assign s_tready = (cnt != (PW+1)'(jts_pkg::QUEUE_DEPTH));
  assign push     = s_tvalid && s_tready;

  assign head.valid = (cnt != '0);
  assign head.item  = q[rp];

  always_ff @(posedge clk) begin
    if (push) begin
      q[wp] <= cur;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (push) begin
        wp <= wp + 1'b1;
      end
      if (pop) begin
        rp <= rp + 1'b1;
      end
      cnt <= cnt + (PW+1)'(push) - (PW+1)'(pop);
    end
  end

endmodule

`default_nettype wire

/* design/jts_back.sv */
// Back end: token state machine, runs one queued byte per cycle while the record queue has room.
`default_nettype none

module jts_back #(
  parameter int OFFSET_WIDTH = 16
) (
  input  wire                  clk,
  input  wire                  rst,
  input  jts_pkg::q_head_t     head,
  output logic                 pop,
  input  jts_pkg::ob_stat_t    ob_stat,
  output jts_pkg::push_t       push
);

  jts_pkg::mode_t mode;
  jts_pkg::mode_t mode_next;
  logic                  quote_single, quote_single_next;
  logic [1:0]            kw_sel, kw_sel_next;
  logic [2:0]            kw_pos, kw_pos_next;
  logic [OFFSET_WIDTH:0] byte_offset, byte_offset_next;
  logic [15:0]           start_offset, start_offset_next;
  logic                  num_flt, num_flt_next;
  logic                  num_neg, num_neg_next;
  logic                  halted, halted_next;

  jts_pkg::cls_item_t it;
  jts_pkg::rec_t      ra, rb, rc;
  logic               a_v, b_v, c_v;
  logic               do_idle;
  logic [15:0]        off16;
  logic [2:0]         kp_inc;
  logic               own_q, other_q;
  logic [1:0]         n;

  function automatic jts_pkg::rec_t mk_rec(input jts_pkg::kind_t kind,
                                           input logic [15:0] start,
                                           input logic [15:0] len,
                                           input logic flt, input logic neg,
                                           input logic bv);
    jts_pkg::rec_t r;
    r.kind   = kind;
    r.start  = start;
    r.length = len;
    r.flt    = flt;
    r.neg    = neg;
    r.bv     = bv;
    r.last   = 1'b0;
    return r;
  endfunction

  assign it     = head.item;
  assign off16  = 16'(byte_offset);
  assign kp_inc = kw_pos + 3'd1;
  assign own_q  = quote_single ? (it.cls == jts_pkg::CC_SQUOTE)
                               : (it.cls == jts_pkg::CC_DQUOTE);
  assign other_q = quote_single ? (it.cls == jts_pkg::CC_DQUOTE)
                                : (it.cls == jts_pkg::CC_SQUOTE);

  always_comb begin
    mode_next         = mode;
    quote_single_next = quote_single;
    kw_sel_next       = kw_sel;
    kw_pos_next       = kw_pos;
    byte_offset_next  = byte_offset;
    start_offset_next = start_offset;
    num_flt_next      = num_flt;
    num_neg_next      = num_neg;
    halted_next       = halted;
    a_v = 1'b0;
    b_v = 1'b0;
    c_v = 1'b0;
    ra  = '0;
    rb  = '0;
    rc  = '0;
    do_idle = 1'b0;

    if (!halted) begin
      if (byte_offset[OFFSET_WIDTH]) begin
        // offset out of range: counter stays parked at the limit
        a_v = 1'b1;
        ra  = mk_rec(jts_pkg::KIND_ERROR, off16, 16'd0, 1'b0, 1'b0, 1'b0);
        halted_next = 1'b1;
        mode_next   = jts_pkg::MODE_IDLE;
      end else begin
        byte_offset_next = byte_offset + 1'b1;
        unique case (mode)
          jts_pkg::MODE_NUM: begin
            if (it.numeric) begin
              num_flt_next = num_flt | it.flt;
              num_neg_next = num_neg | it.neg;
            end else begin
              a_v = 1'b1;
              ra  = mk_rec(jts_pkg::KIND_NUMBER, start_offset, off16 - start_offset,
                           num_flt, num_neg, 1'b0);
              mode_next = jts_pkg::MODE_IDLE;
              do_idle   = 1'b1;
            end
          end
          jts_pkg::MODE_STR: begin
            if (own_q) begin
              a_v = 1'b1;
              ra  = mk_rec(jts_pkg::KIND_STRING, start_offset, off16 - start_offset,
                           1'b0, 1'b0, 1'b0);
              mode_next = jts_pkg::MODE_IDLE;
            end else if (other_q || it.data == 8'h00) begin
              a_v = 1'b1;
              ra  = mk_rec(jts_pkg::KIND_ERROR, off16, 16'd0, 1'b0, 1'b0, 1'b0);
              halted_next = 1'b1;
              mode_next   = jts_pkg::MODE_IDLE;
            end
          end
          jts_pkg::MODE_KEY: begin
            if (it.data == jts_pkg::kw_char(kw_sel, kw_pos)) begin
              if (kp_inc == jts_pkg::kw_len(kw_sel)) begin
                a_v = 1'b1;
                ra  = mk_rec((kw_sel == jts_pkg::KW_TRUE || kw_sel == jts_pkg::KW_FALSE)
                               ? jts_pkg::KIND_BOOL : jts_pkg::KIND_NULL,
                             start_offset, 16'(jts_pkg::kw_len(kw_sel)),
                             1'b0, 1'b0, (kw_sel == jts_pkg::KW_TRUE));
                mode_next   = jts_pkg::MODE_IDLE;
                kw_pos_next = 3'd0;
              end else begin
                kw_pos_next = kp_inc;
              end
            end else begin
              a_v = 1'b1;
              ra  = mk_rec(jts_pkg::KIND_ERROR, off16, 16'd0, 1'b0, 1'b0, 1'b0);
              halted_next = 1'b1;
              mode_next   = jts_pkg::MODE_IDLE;
            end
          end
          default: do_idle = 1'b1;
        endcase

        if (do_idle) begin
          unique case (it.cls)
            jts_pkg::CC_SPACE: ;
            jts_pkg::CC_DQUOTE, jts_pkg::CC_SQUOTE: begin
              mode_next         = jts_pkg::MODE_STR;
              quote_single_next = (it.cls == jts_pkg::CC_SQUOTE);
              start_offset_next = off16 + 16'd1;
            end
            jts_pkg::CC_KEY_T, jts_pkg::CC_KEY_F, jts_pkg::CC_KEY_N: begin
              mode_next = jts_pkg::MODE_KEY;
              kw_sel_next = (it.cls == jts_pkg::CC_KEY_T) ? jts_pkg::KW_TRUE :
                            (it.cls == jts_pkg::CC_KEY_F) ? jts_pkg::KW_FALSE :
                                                            jts_pkg::KW_NULL;
              kw_pos_next       = 3'd1;
              start_offset_next = off16;
            end
            jts_pkg::CC_NUMSTART: begin
              mode_next         = jts_pkg::MODE_NUM;
              start_offset_next = off16;
              num_flt_next      = it.flt;
              num_neg_next      = it.neg;
            end
            jts_pkg::CC_PUNCT: begin
              b_v = 1'b1;
              rb  = mk_rec(it.punct_kind, off16, 16'd1, 1'b0, 1'b0, 1'b0);
            end
            default: begin
              b_v = 1'b1;
              rb  = mk_rec(jts_pkg::KIND_ERROR, off16, 16'd0, 1'b0, 1'b0, 1'b0);
              halted_next = 1'b1;
              mode_next   = jts_pkg::MODE_IDLE;
            end
          endcase
        end
      end

      // end of input closes whatever is still open
      if (it.eoi && !halted_next) begin
        if (mode_next == jts_pkg::MODE_NUM) begin
          c_v = 1'b1;
          rc  = mk_rec(jts_pkg::KIND_NUMBER, start_offset_next,
                       off16 + 16'd1 - start_offset_next,
                       num_flt_next, num_neg_next, 1'b0);
        end else if (mode_next == jts_pkg::MODE_STR || mode_next == jts_pkg::MODE_KEY) begin
          c_v = 1'b1;
          rc  = mk_rec(jts_pkg::KIND_ERROR, off16, 16'd0, 1'b0, 1'b0, 1'b0);
        end
      end
    end

    if (it.eoi) begin
      mode_next         = jts_pkg::MODE_IDLE;
      quote_single_next = 1'b0;
      kw_sel_next       = 2'd0;
      kw_pos_next       = 3'd0;
      byte_offset_next  = '0;
      start_offset_next = 16'd0;
      num_flt_next      = 1'b0;
      num_neg_next      = 1'b0;
      halted_next       = 1'b0;
    end
  end

  // pack up to two of the three candidate records in order
  assign n = 2'(a_v) + 2'(b_v) + 2'(c_v);

  assign pop = head.valid && (3'(n) <= ob_stat.free);

  always_comb begin
    push.n  = pop ? n : 2'd0;
    push.r0 = a_v ? ra : (b_v ? rb : rc);
    push.r1 = a_v ? (b_v ? rb : rc) : rc;
    push.r0.last = (n == 2'd1);
    push.r1.last = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= jts_pkg::MODE_IDLE;
    end else if (pop) begin
      mode <= mode_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      quote_single <= 1'b0;
      kw_sel       <= 2'd0;
      kw_pos       <= 3'd0;
      byte_offset  <= '0;
      start_offset <= 16'd0;
      num_flt      <= 1'b0;
      num_neg      <= 1'b0;
      halted       <= 1'b0;
    end else if (pop) begin
      quote_single <= quote_single_next;
      kw_sel       <= kw_sel_next;
      kw_pos       <= kw_pos_next;
      byte_offset  <= byte_offset_next;
      start_offset <= start_offset_next;
      num_flt      <= num_flt_next;
      num_neg      <= num_neg_next;
      halted       <= halted_next;
    end
  end

endmodule

`default_nettype wire

/* design/jts_outbuf.sv */
// Output record queue: takes up to two records a cycle, sends one a cycle while m_tready is high.
`default_nettype none

module jts_outbuf (
  input  wire                  clk,
  input  wire                  rst,
  input  jts_pkg::push_t       push,
  output jts_pkg::ob_stat_t    stat,
  output logic                 m_tvalid,
  input  wire                  m_tready,
  output jts_pkg::rec_t        head
);

  localparam int PW = $clog2(jts_pkg::OUTBUF_DEPTH);

  jts_pkg::rec_t mem [jts_pkg::OUTBUF_DEPTH];
  logic [PW-1:0] wp;
  logic [PW-1:0] rp;
  logic [PW:0]   cnt;
  logic          pop;

  assign m_tvalid  = (cnt != '0);
  assign pop       = m_tvalid && m_tready;
  assign head      = mem[rp];
  assign stat.free = 3'((PW+1)'(jts_pkg::OUTBUF_DEPTH) - cnt);

  always_ff @(posedge clk) begin
    if (push.n != 2'd0) begin
      mem[wp] <= push.r0;
    end
    if (push.n == 2'd2) begin
      mem[wp + 1'b1] <= push.r1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      wp  <= wp + PW'(push.n);
      if (pop) begin
        rp <= rp + 1'b1;
      end
      cnt <= cnt + (PW+1)'(push.n) - (PW+1)'(pop);
    end
  end

endmodule

`default_nettype wire

/* design/json_token_scanner.sv */
// An accepted byte is registered in the byte queue, and its token records in the record queue.
// Throughput: one byte per cycle while each byte yields at most one record and
// m_tready is high; the single-record output port sets the rate.
// A 4-entry byte queue and a 4-entry record queue decouple the two sides.
// Reset (rst, synchronous): empties both queues and returns the scanner to idle, offset 0.
`default_nettype none
`include "assert_macros.svh"

module json_token_scanner #(
  parameter int OFFSET_WIDTH = 16
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         s_tvalid,
  output logic        s_tready,
  input  wire  [7:0]  s_tdata,   // [7:0] data_byte
  input  wire         s_tlast,   // end_of_input
  output logic        m_tvalid,
  input  wire         m_tready,
  output logic [39:0] m_tdata,   // [15:0] token_start, [31:16] token_length,
                                 // [32] is_floating, [33] is_negative, [34] bool_value
  output logic [3:0]  m_tuser,   // [3:0] token_kind
  output logic        m_tlast    // last_of_item
);

  jts_pkg::q_head_t  q_head;
  logic              q_pop;
  jts_pkg::push_t    bk_push;
  jts_pkg::ob_stat_t ob_stat;
  jts_pkg::rec_t     out_rec;

  jts_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .head     (q_head),
    .pop      (q_pop)
  );

  jts_back #(
    .OFFSET_WIDTH (OFFSET_WIDTH)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .head    (q_head),
    .pop     (q_pop),
    .ob_stat (ob_stat),
    .push    (bk_push)
  );

  jts_outbuf u_outbuf (
    .clk      (clk),
    .rst      (rst),
    .push     (bk_push),
    .stat     (ob_stat),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .head     (out_rec)
  );

  assign m_tdata = {5'd0, out_rec.bv, out_rec.neg, out_rec.flt,
                    out_rec.length, out_rec.start};
  assign m_tuser = out_rec.kind;
  assign m_tlast = out_rec.last;

  // records pushed never overrun the output queue
  `ASSERT_ALWAYS(a_push_room, clk, rst, 3'(bk_push.n) <= ob_stat.free)
  // an accepted byte is visible to the back end on the next cycle
  `ASSERT_NEXT(a_front_fill, clk, rst, s_tvalid && s_tready, q_head.valid)
  // error records carry zero length
  `ASSERT_IMPLIES(a_err_len, clk, rst, m_tvalid && m_tuser == jts_pkg::KIND_ERROR,
                  m_tdata[31:16] == 16'd0)
  // number flags only on number records
  `ASSERT_IMPLIES(a_num_flags, clk, rst, m_tvalid && m_tuser != jts_pkg::KIND_NUMBER,
                  m_tdata[33:32] == 2'd0)

endmodule

`default_nettype wire
